FILE: hdl/ole_pkg.sv
`timescale 1ns / 1ps

package ole_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 3;
    localparam int FOUND_W = 6;
    localparam int TOTAL_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INS_END = 3'd0,
        OP_INS_BEG = 3'd1,
        OP_INS_POS = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_REM_END = 3'd4,
        OP_REM_BEG = 3'd5,
        OP_REM_VAL = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [FOUND_W-1:0]   found_position;
        logic [TOTAL_W-1:0]   element_total;
    } res_t;

endpackage

FILE: hdl/ole_ram.sv
`timescale 1ns / 1ps

module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/ole_ctrl.sv
`timescale 1ns / 1ps

module ole_ctrl #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ole_pkg::OP_W-1:0]            op,
    input  logic signed [ole_pkg::VAL_W-1:0]    item_value,
    input  logic [ole_pkg::POS_W-1:0]           insert_position,
    output logic                                done_valid,
    input  logic                                done_ack,
    output ole_pkg::res_t                       res,
    output logic                                ram_we,
    output logic [AW-1:0]                       ram_waddr,
    output logic [ole_pkg::VAL_W-1:0]           ram_wdata,
    output logic                                ram_re,
    output logic [AW-1:0]                       ram_raddr,
    input  logic [ole_pkg::VAL_W-1:0]           ram_rdata
);

    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int FW = (AW > FOUND_W) ? AW : FOUND_W;
    localparam int TW = (CW > TOTAL_W) ? CW : TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WRITE,
        S_SEARCH,
        S_SHIFT_DN,
        S_FINISH
    } state_t;

    state_t                   state_reg,  state_next;
    op_t                      op_reg,     op_next;
    logic signed [VAL_W-1:0]  val_reg,    val_next;
    logic [CW-1:0]            count_reg,  count_next;
    logic [AW-1:0]            idx_reg,    idx_next;
    logic [AW-1:0]            tgt_reg,    tgt_next;
    status_t                  status_reg, status_next;
    logic [AW-1:0]            found_reg,  found_next;

    logic [PW-1:0]            cnt_ext;
    logic [PW-1:0]            tgt_ext;
    logic [AW-1:0]            last_idx;
    logic [AW-1:0]            idx_inc;
    logic [AW-1:0]            idx_dec;
    logic                     full;
    logic                     empty;
    logic                     last_hit;
    logic                     match;
    logic [FW-1:0]            found_wide;
    logic [TW-1:0]            total_wide;

    always_comb
    begin
        cnt_ext  = PW'(count_reg);
        last_idx = AW'(count_reg - CW'(1));
        idx_inc  = idx_reg + AW'(1);
        idx_dec  = idx_reg - AW'(1);
        full     = (count_reg == CW'(CAPACITY));
        empty    = (count_reg == '0);
        last_hit = (idx_reg == last_idx);
        match    = (ram_rdata == val_reg);

        unique case (op_t'(op))
            OP_INS_END: tgt_ext = cnt_ext;
            OP_INS_BEG: tgt_ext = '0;
            default:    tgt_ext = PW'(insert_position);
        endcase

        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        tgt_next    = tgt_reg;
        status_next = status_reg;
        found_next  = found_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_inc;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(op);
                    val_next    = item_value;
                    status_next = ST_OK;
                    found_next  = '0;
                    state_next  = S_FINISH;
                    unique case (op_t'(op))
                        OP_INS_END, OP_INS_BEG, OP_INS_POS:
                        begin
                            if (tgt_ext > cnt_ext)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (tgt_ext == cnt_ext)
                            begin
                                // Appending needs no shift: write the tail slot now.
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = item_value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                // Move the tail up one slot, last element first.
                                ram_re     = 1'b1;
                                ram_raddr  = last_idx;
                                idx_next   = last_idx;
                                tgt_next   = tgt_ext[AW-1:0];
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_SEARCH, OP_REM_VAL:
                        begin
                            if (empty)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_REM_END:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_REM_BEG:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (last_idx == '0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(1);
                                idx_next   = AW'(1);
                                state_next = S_SHIFT_DN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_inc;
                ram_wdata = ram_rdata;
                if (idx_reg == tgt_reg)
                begin
                    state_next = S_INS_WRITE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec;
                    idx_next  = idx_dec;
                end
            end
            S_INS_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = tgt_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FINISH;
            end
            S_SEARCH:
            begin
                if (match)
                begin
                    if (op_reg == OP_SEARCH)
                    begin
                        found_next = idx_reg;
                        state_next = S_FINISH;
                    end
                    else if (last_hit)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // Close the gap left by the matching element.
                        ram_re     = 1'b1;
                        ram_raddr  = idx_inc;
                        idx_next   = idx_inc;
                        state_next = S_SHIFT_DN;
                    end
                end
                else if (last_hit)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end
            S_SHIFT_DN:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_dec;
                ram_wdata = ram_rdata;
                if (last_hit)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end
            S_FINISH:
            begin
                if (done_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        tgt_reg    <= tgt_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    always_comb
    begin
        found_wide         = FW'(found_reg);
        total_wide         = TW'(count_reg);
        res.status         = status_reg;
        res.found_position = found_wide[FOUND_W-1:0];
        res.element_total  = total_wide[TOTAL_W-1:0];
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_FINISH);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(CAPACITY)))
        else $error("element count above capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((CW + 1)'(ram_waddr) <= (CW + 1)'(count_reg)))
        else $error("store written beyond the list end");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after an input transfer");

    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_UP) |-> (idx_reg >= tgt_reg))
        else $error("insert shift passed its target slot");

endmodule

FILE: hdl/ordered_list_engine_core.sv
`timescale 1ns / 1ps
// Append, tail or head removal of a single element and failed requests go from the input
// transfer to the controller finish state and then into the output register; shifting
// or searching visits the elements one at a time through the single store read port.
// One request at a time; the next input can be taken once the result enters the output
// register, which holds it while the next request runs.
// Reset clears the element count, controller state and output valid, not the store.

module ordered_list_engine_core #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ole_pkg::OP_W-1:0]            op,
    input  logic signed [ole_pkg::VAL_W-1:0]    item_value,
    input  logic [ole_pkg::POS_W-1:0]           insert_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ole_pkg::STAT_W-1:0]          status,
    output logic [ole_pkg::FOUND_W-1:0]         found_position,
    output logic [ole_pkg::TOTAL_W-1:0]         element_total
);

    import ole_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              done_valid;
    logic              res_free;
    res_t              done_res;
    res_t              res_reg;
    logic              out_valid_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    ole_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .item_value      (item_value),
        .insert_position (insert_position),
        .done_valid      (done_valid),
        .done_ack        (res_free),
        .res             (done_res),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata)
    );

    ole_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register can take a new result when empty or when its
    // current result is being transferred in this cycle.
    assign res_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_valid && res_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && res_free)
        begin
            res_reg <= done_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = res_reg.status;
    assign found_position = res_reg.found_position;
    assign element_total  = res_reg.element_total;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ole_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;

    localparam int RANDOM_REQUESTS = 1700;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         pos;
        bit                       hold;
    } list_request_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [OP_W-1:0]            op = '0;
    logic signed [VAL_W-1:0]    item_value = '0;
    logic [POS_W-1:0]           insert_position = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STAT_W-1:0]          status;
    logic [FOUND_W-1:0]         found_position;
    logic [TOTAL_W-1:0]         element_total;

    list_request_t              queued_requests[$];
    list_request_t              request_in_transfer;
    res_t                       awaited_replies[$];
    logic signed [VAL_W-1:0]    list_contents[$];

    int                         burst_left = 1;
    int                         gap_left = 0;
    int                         mismatch_count = 0;
    int                         stall_mode = STALL_NONE;
    int                         stall_cycles = 0;
    logic [15:0]                stall_pattern = 16'hB3D5;

    ordered_list_engine_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .item_value      (item_value),
        .insert_position (insert_position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found_position  (found_position),
        .element_total   (element_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Applies one request to the list copy and returns the reply the block should give.
    function automatic res_t apply_request(list_request_t r);
        res_t reply;
        int   hit;
        int   i;
        reply.status = ST_OK;
        reply.found_position = '0;
        hit = -1;
        case (r.op)
            OP_INS_END, OP_INS_BEG:
            begin
                if (list_contents.size() >= CAPACITY_DEF)
                    reply.status = ST_FULL;
                else if (r.op == OP_INS_END)
                    list_contents.push_back(r.value);
                else
                    list_contents.push_front(r.value);
            end
            OP_INS_POS:
            begin
                // A position past the count wins over a full list.
                if (r.pos > list_contents.size())
                    reply.status = ST_BAD_POS;
                else if (list_contents.size() >= CAPACITY_DEF)
                    reply.status = ST_FULL;
                else if (r.pos == list_contents.size())
                    list_contents.push_back(r.value);
                else
                    list_contents.insert(r.pos, r.value);
            end
            OP_SEARCH, OP_REM_VAL:
            begin
                for (i = 0; i < list_contents.size(); i++)
                begin
                    if (hit < 0 && list_contents[i] == r.value)
                        hit = i;
                end
                if (hit < 0)
                    reply.status = ST_NOT_FOUND;
                else if (r.op == OP_SEARCH)
                    reply.found_position = hit[FOUND_W-1:0];
                else
                    list_contents.delete(hit);
            end
            OP_REM_END, OP_REM_BEG:
            begin
                if (list_contents.size() == 0)
                    reply.status = ST_EMPTY;
                else if (r.op == OP_REM_END)
                    void'(list_contents.pop_back());
                else
                    void'(list_contents.pop_front());
            end
            default:
            begin
            end
        endcase
        reply.element_total = TOTAL_W'(list_contents.size());
        return reply;
    endfunction

    task automatic add_request(logic [OP_W-1:0] o, logic signed [VAL_W-1:0] v,
                               logic [POS_W-1:0] p, bit hold);
        list_request_t r;
        r.op = o;
        r.value = v;
        r.pos = p;
        r.hold = hold;
        queued_requests.push_back(r);
    endtask

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                awaited_replies.push_back(apply_request(request_in_transfer));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (queued_requests.size() == 0 ||
                         (queued_requests[0].hold && awaited_replies.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    request_in_transfer = queued_requests.pop_front();
                    op <= request_in_transfer.op;
                    item_value <= request_in_transfer.value;
                    insert_position <= request_in_transfer.pos;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: checks each transfer and stalls in one of several modes.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected reply status=%0d found=%0d total=%0d",
                                              status, found_position, element_total));
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (status !== want.status || found_position !== want.found_position ||
                        element_total !== want.element_total)
                        report_mismatch($sformatf(
                            "expected status=%0d found=%0d total=%0d, got %0d %0d %0d",
                            want.status, want.found_position, want.element_total,
                            status, found_position, element_total));
                end
            end
            stall_cycles++;
            if (stall_cycles % 256 == 0)
                stall_mode = $urandom_range(STALL_NONE, STALL_PATTERN);
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            case (stall_mode)
                STALL_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                STALL_PATTERN: out_ready <= stall_pattern[0];
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    initial
    begin
        int                       mode;
        int                       mode_left;
        int                       est_count;
        int                       r;
        logic [OP_W-1:0]          o;
        logic signed [VAL_W-1:0]  v;
        logic [POS_W-1:0]         p;

        // Corner cases on the empty list first, then small edits with extreme values.
        add_request(OP_REM_END, 32'sd0, 7'd0, 1'b0);
        add_request(OP_REM_BEG, 32'sd0, 7'd0, 1'b0);
        add_request(OP_SEARCH, 32'sd0, 7'd0, 1'b0);
        add_request(OP_REM_VAL, 32'sd0, 7'd0, 1'b0);
        add_request(OP_INS_POS, 32'sd9, 7'd1, 1'b0);
        add_request(OP_UNUSED, -32'sd1, 7'd127, 1'b0);
        add_request(OP_INS_POS, 32'sh8000_0000, 7'd0, 1'b0);
        add_request(OP_INS_END, 32'sh7FFF_FFFF, 7'd0, 1'b0);
        add_request(OP_INS_BEG, 32'sd0, 7'd0, 1'b0);
        add_request(OP_INS_POS, -32'sd1, 7'd3, 1'b0);
        add_request(OP_INS_POS, 32'sd5, 7'd1, 1'b0);
        add_request(OP_INS_POS, 32'sd7, 7'd127, 1'b0);
        add_request(OP_INS_POS, 32'sd7, 7'd64, 1'b0);
        add_request(OP_SEARCH, 32'sh7FFF_FFFF, 7'd0, 1'b0);
        add_request(OP_SEARCH, -32'sd1, 7'd0, 1'b0);
        add_request(OP_SEARCH, 32'sd12345, 7'd0, 1'b0);
        add_request(OP_INS_END, 32'sd5, 7'd0, 1'b0);
        add_request(OP_REM_VAL, 32'sd5, 7'd0, 1'b0);
        add_request(OP_SEARCH, 32'sd5, 7'd0, 1'b0);
        add_request(OP_REM_VAL, 32'sd12345, 7'd0, 1'b0);
        add_request(OP_REM_END, 32'sd0, 7'd0, 1'b0);
        add_request(OP_REM_BEG, 32'sd0, 7'd0, 1'b0);
        add_request(OP_UNUSED, 32'sd3, 7'd0, 1'b1);

        // Random phases lean toward filling or draining so the list often reaches
        // full and empty; values mostly come from a small set so matches are common.
        est_count = 3;
        mode = MODE_FILL;
        mode_left = 120;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(MODE_FILL, MODE_MIX);
                mode_left = $urandom_range(60, 160);
            end
            mode_left--;
            r = $urandom_range(0, 99);
            case (mode)
                MODE_FILL:
                    o = (r < 28) ? OP_INS_END : (r < 52) ? OP_INS_BEG :
                        (r < 78) ? OP_INS_POS : (r < 86) ? OP_SEARCH :
                        (r < 91) ? OP_REM_VAL : (r < 95) ? OP_REM_END :
                        (r < 98) ? OP_REM_BEG : OP_UNUSED;
                MODE_DRAIN:
                    o = (r < 6) ? OP_INS_END : (r < 12) ? OP_INS_BEG :
                        (r < 18) ? OP_INS_POS : (r < 32) ? OP_SEARCH :
                        (r < 54) ? OP_REM_VAL : (r < 76) ? OP_REM_END :
                        (r < 98) ? OP_REM_BEG : OP_UNUSED;
                default:
                    o = (r < 14) ? OP_INS_END : (r < 28) ? OP_INS_BEG :
                        (r < 44) ? OP_INS_POS : (r < 60) ? OP_SEARCH :
                        (r < 74) ? OP_REM_VAL : (r < 86) ? OP_REM_END :
                        (r < 98) ? OP_REM_BEG : OP_UNUSED;
            endcase
            if ($urandom_range(0, 99) < 65)
            begin
                case ($urandom_range(0, 7))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    4: v = 32'sd1;
                    5: v = 32'sd2;
                    6: v = 32'sd3;
                    default: v = 32'sd42;
                endcase
            end
            else
            begin
                v = $urandom;
            end
            r = $urandom_range(0, 99);
            if (r < 75)
                p = POS_W'($urandom_range(0, est_count));
            else if (r < 90)
                p = POS_W'($urandom_range(0, CAPACITY_DEF));
            else
                p = POS_W'($urandom_range(0, 127));
            // Rough count only steers positions; prediction does not rely on it.
            if ((o == OP_INS_END || o == OP_INS_BEG ||
                 (o == OP_INS_POS && p <= est_count)) && est_count < CAPACITY_DEF)
                est_count++;
            else if ((o == OP_REM_END || o == OP_REM_BEG) && est_count > 0)
                est_count--;
            add_request(o, v, p, (i % 400 == 399));
        end

        @(posedge rst_n);
        while (queued_requests.size() != 0 || in_valid || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (CAPACITY_DEF + 16) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS ordered_list_engine_core");
        else
            $display("FAIL ordered_list_engine_core");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("FAIL ordered_list_engine_core");
        $finish;
    end

endmodule
